>>> rtl/upd_pkg.sv
package upd_pkg;

	localparam int unsigned MaxOut = 3;

	localparam logic [7:0] ChrPct  = 8'h25;
	localparam logic [7:0] ChrNul  = 8'h00;
	localparam logic [7:0] DigLow  = 8'h32;
	localparam logic [7:0] DigHigh = 8'h37;

	localparam logic [1:0] PendNone  = 2'd0;
	localparam logic [1:0] PendPct   = 2'd1;
	localparam logic [1:0] PendDigit = 2'd2;

	// decoded bytes produced by one source byte, oldest in slot 0
	typedef struct packed {
		logic [MaxOut-1:0][7:0] bytes;
		logic [1:0]             cnt;
		logic                   last;
	} upd_entry_t;

endpackage

>>> rtl/upd_in_if.sv
interface upd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last_in;

	modport source (output valid, output in_byte, output last_in, input ready);
	modport sink (input valid, input in_byte, input last_in, output ready);
endinterface

>>> rtl/upd_out_if.sv
interface upd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_out;

	modport source (output valid, output out_byte, output last_out, input ready);
	modport sink (input valid, input out_byte, input last_out, output ready);
endinterface

>>> rtl/url_percent_decoder_core.sv
// Path: the decoded bytes of a source byte are written into the entry queue as one entry,
// then loaded into the output register (cur_q) before the first of them is offered.
// Throughput: one source byte per cycle; one decoded byte per cycle out while dout.ready
// is high, with a source byte yielding zero to three bytes; the entry queue (QueueDepth)
// absorbs bursts. Input stalls only while that queue is full.
// Reset: arst_n clears held escape state, discard mode, queue and output stage.
module url_percent_decoder_core
	import upd_pkg::*;
#(
	parameter int unsigned QueueDepth = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	upd_in_if.sink    din,
	upd_out_if.source dout
);

	logic       full;
	logic       push;
	upd_entry_t push_data;
	logic       pop;
	logic       avail;
	upd_entry_t pop_data;

	upd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	upd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.avail     (avail),
		.pop_data  (pop_data)
	);

	upd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.avail    (avail),
		.pop_data (pop_data),
		.pop      (pop),
		.dout     (dout)
	);

endmodule

>>> rtl/upd_front.sv
module upd_front
	import upd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	upd_in_if.sink      din,
	input  logic        full,
	output logic        push,
	output upd_entry_t  push_data
);

	localparam int unsigned NumCodes = 25;
	localparam logic [NumCodes-1:0][7:0] Codes = {
		8'h20, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2B, 8'h2C, 8'h2F, 8'h3A,
		8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5B, 8'h5C, 8'h5D, 8'h5E,
		8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E
	};

	logic [1:0] pend_cnt_q;
	logic [7:0] pend_dig_q;
	logic       disc_q;

	logic [1:0] pend_cnt_d;
	logic [7:0] pend_dig_d;
	logic       disc_d;

	logic       acc;
	logic [7:0] b;
	logic [3:0] lo_val;
	logic       lo_ok;
	logic [7:0] code;
	logic       listed;
	logic [MaxOut-1:0][7:0] nb;
	logic [1:0] n;
	logic       lastf;

	assign b   = din.in_byte;
	assign acc = din.valid && din.ready;
	assign din.ready = !full;

	always_comb begin
		lo_ok  = 1'b1;
		lo_val = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			lo_val = b[3:0];
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			lo_val = b[3:0] + 4'd9;
		end else begin
			lo_ok = 1'b0;
		end
	end

	assign code = {pend_dig_q[3:0], lo_val};

	always_comb begin
		listed = 1'b0;
		for (int i = 0; i < NumCodes; i++) begin
			if (Codes[i] == code) listed = 1'b1;
		end
	end

	always_comb begin
		nb         = '0;
		n          = 2'd0;
		lastf      = 1'b0;
		pend_cnt_d = pend_cnt_q;
		pend_dig_d = pend_dig_q;
		disc_d     = disc_q;
		if (disc_q) begin
			if (din.last_in) disc_d = 1'b0;
		end else if (b == ChrNul) begin
			if (pend_cnt_q == PendPct || pend_cnt_q == PendDigit) begin
				nb[n] = ChrPct;
				n = n + 2'd1;
			end
			if (pend_cnt_q == PendDigit) begin
				nb[n] = pend_dig_q;
				n = n + 2'd1;
			end
			pend_cnt_d = PendNone;
			pend_dig_d = '0;
			lastf      = 1'b1;
			disc_d     = !din.last_in;
		end else begin
			unique case (pend_cnt_q)
				PendPct: begin
					if (b >= DigLow && b <= DigHigh) begin
						pend_cnt_d = PendDigit;
						pend_dig_d = b;
					end else begin
						nb[n] = ChrPct;
						n = n + 2'd1;
						pend_cnt_d = PendNone;
						if (b == ChrPct) begin
							pend_cnt_d = PendPct;
						end else begin
							nb[n] = b;
							n = n + 2'd1;
						end
					end
				end
				PendDigit: begin
					pend_cnt_d = PendNone;
					pend_dig_d = '0;
					if (lo_ok && listed) begin
						nb[n] = code;
						n = n + 2'd1;
					end else begin
						nb[n] = ChrPct;
						n = n + 2'd1;
						nb[n] = pend_dig_q;
						n = n + 2'd1;
						if (b == ChrPct) begin
							pend_cnt_d = PendPct;
						end else begin
							nb[n] = b;
							n = n + 2'd1;
						end
					end
				end
				default: begin
					pend_cnt_d = PendNone;
					if (b == ChrPct) begin
						pend_cnt_d = PendPct;
					end else begin
						nb[n] = b;
						n = n + 2'd1;
					end
				end
			endcase
			if (din.last_in) begin
				// flush held bytes; at most three bytes can result in total
				if (pend_cnt_d == PendPct || pend_cnt_d == PendDigit) begin
					if (n < 2'd3) begin
						nb[n] = ChrPct;
						n = n + 2'd1;
					end
				end
				if (pend_cnt_d == PendDigit) begin
					if (n < 2'd3) begin
						nb[n] = pend_dig_d;
						n = n + 2'd1;
					end
				end
				pend_cnt_d = PendNone;
				pend_dig_d = '0;
				lastf      = 1'b1;
			end
		end
	end

	assign push           = acc && (n != 2'd0);
	assign push_data.bytes = nb;
	assign push_data.cnt   = n;
	assign push_data.last  = lastf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= PendNone;
			pend_dig_q <= '0;
			disc_q     <= 1'b0;
		end else if (acc) begin
			pend_cnt_q <= pend_cnt_d;
			pend_dig_q <= pend_dig_d;
			disc_q     <= disc_d;
		end
	end

endmodule

>>> rtl/upd_queue.sv
module upd_queue
	import upd_pkg::*;
#(
	parameter int unsigned Depth = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  upd_entry_t push_data,
	output logic       full,
	input  logic       pop,
	output logic       avail,
	output upd_entry_t pop_data
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntMax = CntW'(Depth);

	upd_entry_t mem [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign full     = (cnt_q == CntMax);
	assign avail    = (cnt_q != '0);
	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> rtl/upd_back.sv
module upd_back
	import upd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        avail,
	input  upd_entry_t  pop_data,
	output logic        pop,
	upd_out_if.source   dout
);

	upd_entry_t cur_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       done;
	logic       xfer;

	assign done = (idx_q == cur_q.cnt - 2'd1);
	assign xfer = dout.valid && dout.ready;
	// refill when idle, or as the last byte of the current entry transfers
	assign pop  = avail && (!busy_q || (xfer && done));

	assign dout.valid    = busy_q;
	assign dout.out_byte = cur_q.bytes[idx_q];
	assign dout.last_out = cur_q.last && done;

	always_ff @(posedge clk) begin
		if (pop) cur_q <= pop_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (xfer) begin
			if (done) busy_q <= 1'b0;
			else      idx_q  <= idx_q + 2'd1;
		end
	end

endmodule

>>> sim/testbench.sv
module testbench;
	import upd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned TargetItems = 400;
	localparam int unsigned HoldCycles = 200;

	// codes that an escape may decode to; everything else passes through as text
	localparam logic [7:0] Listed [25] = '{
		8'h20, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2B, 8'h2C, 8'h2F, 8'h3A,
		8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5B, 8'h5C, 8'h5D, 8'h5E,
		8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E
	};

	class decode_scoreboard;
		typedef struct packed {
			logic [7:0] ch;
			logic       last;
		} dec_byte_t;

		dec_byte_t  decoded_q[$];
		dec_byte_t  step_q[$];
		logic [1:0] held_cnt;
		logic [7:0] held_dig;
		bit         skipping;
		int         errors;

		function new();
			held_cnt = PendNone;
			held_dig = '0;
			skipping = 1'b0;
			errors = 0;
		endfunction

		function int hex_nibble(logic [7:0] c);
			if (c >= "0" && c <= "9") return int'(c) - int'("0");
			if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
			if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
			return -1;
		endfunction

		function bit is_listed(logic [7:0] code);
			foreach (Listed[i])
				if (Listed[i] == code) return 1'b1;
			return 1'b0;
		endfunction

		function void put(logic [7:0] c);
			dec_byte_t e;
			e.ch = c;
			e.last = 1'b0;
			if (step_q.size() < MaxOut) step_q.push_back(e);
		endfunction

		function void scan(logic [7:0] c);
			if (c == ChrPct) held_cnt = PendPct;
			else put(c);
		endfunction

		function void flush_held();
			if (held_cnt == PendPct) begin
				put(ChrPct);
			end else if (held_cnt == PendDigit) begin
				put(ChrPct);
				put(held_dig);
			end
			held_cnt = PendNone;
			held_dig = '0;
		endfunction

		// returns 0 when the byte falls in the dropped tail of a token
		function bit decode_source(logic [7:0] b, logic l);
			int lo;
			logic [7:0] code;
			bit ends;
			step_q.delete();
			if (skipping) begin
				if (l) skipping = 1'b0;
				return 1'b0;
			end
			ends = l;
			if (b == ChrNul) begin
				flush_held();
				skipping = !l;
				ends = 1'b1;
			end else begin
				case (held_cnt)
					PendPct: begin
						if (b >= DigLow && b <= DigHigh) begin
							held_cnt = PendDigit;
							held_dig = b;
						end else begin
							put(ChrPct);
							held_cnt = PendNone;
							scan(b);
						end
					end
					PendDigit: begin
						lo = hex_nibble(b);
						code = {held_dig[3:0], (lo < 0) ? 4'h0 : lo[3:0]};
						if (lo >= 0 && is_listed(code)) begin
							put(code);
							held_cnt = PendNone;
							held_dig = '0;
						end else begin
							put(ChrPct);
							put(held_dig);
							held_cnt = PendNone;
							held_dig = '0;
							scan(b);
						end
					end
					default: begin
						held_cnt = PendNone;
						scan(b);
					end
				endcase
				if (l) flush_held();
			end
			if (ends && step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
			foreach (step_q[i]) decoded_q.push_back(step_q[i]);
			return 1'b1;
		endfunction

		function void check_decoded(logic [7:0] ch, logic l);
			dec_byte_t want;
			if (decoded_q.size() == 0) begin
				$display("%0t: unexpected decoded byte: expected none, actual %h last %b",
					$time, ch, l);
				errors++;
				return;
			end
			want = decoded_q.pop_front();
			if (ch !== want.ch) begin
				$display("%0t: out_byte mismatch: expected %h, actual %h", $time, want.ch, ch);
				errors++;
			end
			if (l !== want.last) begin
				$display("%0t: last_out mismatch on %h: expected %b, actual %b",
					$time, want.ch, want.last, l);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	upd_in_if  src_ch ();
	upd_out_if dec_ch ();

	url_percent_decoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (src_ch),
		.dout   (dec_ch)
	);

	decode_scoreboard sb;
	logic [7:0]       tok_q[$];
	int               src_count;
	int unsigned      cycle_count;
	int unsigned      hold_left;
	bit               hold_req;
	bit               calm;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("== FAIL ==");
		$finish;
	end

	// sink side: check each transfer, then pick ready for the next edge
	initial begin
		dec_ch.ready <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && dec_ch.valid && dec_ch.ready)
				sb.check_decoded(dec_ch.out_byte, dec_ch.last_out);
			if (hold_req) begin
				hold_left = HoldCycles;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				dec_ch.ready <= 1'b0;
			end else begin
				dec_ch.ready <= calm || ($urandom_range(0, 99) >= 38);
			end
		end
	end

	function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
		if (n < 10) return 8'("0") + 8'(n);
		return (upper ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] hexish();
		if ($urandom_range(0, 9) < 7)
			return hex_char(4'($urandom_range(0, 15)), bit'($urandom_range(0, 1)));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void fill_token();
		int segs;
		int r;
		logic [7:0] code;
		bit noise;
		tok_q.delete();
		segs = $urandom_range(1, 6);
		noise = ($urandom_range(0, 9) == 0);
		for (int s = 0; s < segs; s++) begin
			r = noise ? 99 : $urandom_range(0, 99);
			if (r < 35) begin
				code = Listed[$urandom_range(0, 24)];
				tok_q.push_back(ChrPct);
				tok_q.push_back(hex_char(code[7:4], 1'b0));
				tok_q.push_back(hex_char(code[3:0], bit'($urandom_range(0, 1))));
			end else if (r < 52) begin
				// partial or unlisted escape
				tok_q.push_back(ChrPct);
				if ($urandom_range(0, 3) != 0)
					tok_q.push_back(8'("0") + 8'($urandom_range(1, 8)));
				if ($urandom_range(0, 2) != 0) tok_q.push_back(hexish());
			end else if (r < 55) begin
				tok_q.push_back(ChrNul);
			end else if (r < 68) begin
				tok_q.push_back(($urandom_range(0, 1) != 0) ? ChrPct : hexish());
			end else begin
				tok_q.push_back(8'($urandom_range(0, 255)));
			end
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic l);
		while (!calm && $urandom_range(0, 99) < 38) begin
			src_ch.valid <= 1'b0;
			@(posedge clk);
		end
		src_ch.valid <= 1'b1;
		src_ch.in_byte <= b;
		src_ch.last_in <= l;
		@(posedge clk);
		while (!src_ch.ready) @(posedge clk);
		if (sb.decode_source(b, l)) src_count++;
	endtask

	task automatic send_token();
		foreach (tok_q[i]) send_byte(tok_q[i], i == tok_q.size() - 1);
	endtask

	task automatic send_random_until(input int goal);
		while (src_count < goal) begin
			fill_token();
			send_token();
		end
	endtask

	task automatic wait_drained();
		src_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.decoded_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		sb = new();
		src_count = 0;
		hold_req = 1'b0;
		calm = 1'b0;
		arst_n <= 1'b0;
		src_ch.valid <= 1'b0;
		src_ch.in_byte <= '0;
		src_ch.last_in <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// listed escape, both letter cases
		tok_q = '{ChrPct, "2", "b"};
		send_token();
		tok_q = '{ChrPct, "7", "E"};
		send_token();
		// escape broken by a non-hex byte at token end
		tok_q = '{ChrPct, "2", "G"};
		send_token();
		// percent breaks a match, scanning resumes at it
		tok_q = '{ChrPct, ChrPct, "2", "0"};
		send_token();
		// zero byte mid-token: flush, then drop up to last
		tok_q = '{8'hFF, ChrPct, ChrNul, "a", 8'h80};
		send_token();
		// token with nothing to output
		tok_q = '{ChrNul};
		send_token();
		// unlisted code passes through
		tok_q = '{ChrPct, "4", "1"};
		send_token();
		// zero byte with a digit held
		tok_q = '{ChrPct, "3", ChrNul};
		send_token();

		send_random_until(150);

		// receiver holds off while the sender keeps offering
		hold_req = 1'b1;
		send_random_until(200);

		calm = 1'b1;
		send_random_until(280);
		calm = 1'b0;

		wait_drained();
		send_random_until(TargetItems);

		wait_drained();
		if (sb.errors == 0 && sb.decoded_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
